// ===== src/ptc_pkg.sv =====
// shared types and constants for the pressure/temperature compensation block
// no dependencies
package ptc_pkg;

	localparam int T_OFFSET = 128000;
	localparam int P_BASE = 1048576;
	localparam int P_SCALE = 3125;
	localparam logic signed [63:0] P_BIAS = 64'sh0000_8000_0000_0000;
	// ceil(2^21 / 10), exact for magnitudes below 2^17
	localparam int RECIP_10 = 209716;
	// ceil(2^32 / 25), exact for values below 2^22
	localparam int RECIP_25 = 171798692;

	typedef enum logic [2:0] {
		REG_T1,
		REG_T2,
		REG_T3,
		REG_P1,
		REG_P2,
		REG_P3,
		REG_P456,
		REG_P789
	} ptc_reg_t;

	typedef struct packed {
		logic [15:0] t1;
		logic [15:0] t2;
		logic [15:0] t3;
		logic [15:0] p1;
		logic [15:0] p2;
		logic [15:0] p3;
		logic [15:0] p4;
		logic [15:0] p5;
		logic [15:0] p6;
		logic [15:0] p7;
		logic [15:0] p8;
		logic [15:0] p9;
	} ptc_coeff_t;

	typedef struct packed {
		logic [19:0] adc_p;
		logic [24:0] v1;
		logic [31:0] tc;
		logic [15:0] tenths;
	} ptc_item_t;

	typedef struct packed {
		logic        pvalid;
		logic [31:0] tc;
		logic [15:0] tenths;
	} ptc_tag_t;

	typedef struct packed {
		logic        vld;
		logic        neg;
		logic [63:0] ua;
		logic [30:0] ub;
		ptc_tag_t    tag;
	} ptc_div_in_t;

	typedef struct packed {
		logic        vld;
		logic        neg;
		logic [63:0] quo;
		ptc_tag_t    tag;
	} ptc_div_out_t;

endpackage

// ===== src/ptc_if.sv =====
// valid/ready channel interfaces for raw samples and compensated results
// no dependencies
interface ptc_in_if;
	logic        valid;
	logic        ready;
	logic [19:0] raw_pressure;
	logic [19:0] raw_temperature;

	modport source(output valid, output raw_pressure, output raw_temperature, input ready);
	modport sink(input valid, input raw_pressure, input raw_temperature, output ready);
endinterface

interface ptc_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] temperature_centi;
	logic [31:0]        pressure_q24_8;
	logic               pressure_valid;
	logic signed [15:0] temperature_tenths;
	logic [15:0]        pressure_hpa;

	modport source(output valid, output temperature_centi, output pressure_q24_8,
		output pressure_valid, output temperature_tenths, output pressure_hpa, input ready);
	modport sink(input valid, input temperature_centi, input pressure_q24_8,
		input pressure_valid, input temperature_tenths, input pressure_hpa, output ready);
endinterface

// ===== src/ptc_front.sv =====
// front part: accepts samples, computes fine temperature and the temperature outputs
// depends on ptc_pkg and ptc_if
module ptc_front import ptc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	ptc_in_if.sink     in_ch,
	input  ptc_coeff_t coeff,
	input  logic       push_ok,
	output logic       push,
	output ptc_item_t  push_item
);

	logic en;
	logic acc;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;

	logic signed [18:0] x1_s1;
	logic signed [17:0] d_s1;
	logic signed [34:0] a1_s2;
	logic [32:0]        dd_s2;
	logic signed [23:0] ta_s3;
	logic signed [37:0] b_s3;
	logic signed [23:0] tfine_s4;
	logic signed [18:0] tc_s5;
	logic signed [24:0] v1_s5;
	logic               neg_s6;
	logic [35:0]        prod_s6;
	logic signed [18:0] tc_s6;
	logic signed [24:0] v1_s6;
	logic signed [31:0] tc_s7;
	logic signed [24:0] v1_s7;
	logic [15:0]        tenths_s7;
	logic [19:0] adcp_s1, adcp_s2, adcp_s3, adcp_s4, adcp_s5, adcp_s6, adcp_s7;
	logic [17:0] mag;

	assign en = push_ok;
	assign in_ch.ready = en;
	assign acc = in_ch.valid & in_ch.ready;
	assign mag = tc_s5[18] ? 18'(-tc_s5) : 18'(tc_s5);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s1 <= acc;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x1_s1 <= $signed({2'b0, in_ch.raw_temperature[19:3]})
				- $signed({2'b0, coeff.t1, 1'b0});
			d_s1 <= $signed({2'b0, in_ch.raw_temperature[19:4]}) - $signed({2'b0, coeff.t1});
			adcp_s1 <= in_ch.raw_pressure;

			a1_s2 <= 35'(x1_s1) * 35'($signed(coeff.t2));
			dd_s2 <= 33'(36'(d_s1) * 36'(d_s1));
			adcp_s2 <= adcp_s1;

			ta_s3 <= 24'(a1_s2 >>> 11);
			b_s3 <= 38'($signed({1'b0, dd_s2[32:12]})) * 38'($signed(coeff.t3));
			adcp_s3 <= adcp_s2;

			tfine_s4 <= ta_s3 + 24'(b_s3 >>> 14);
			adcp_s4 <= adcp_s3;

			tc_s5 <= 19'((27'(tfine_s4) * 27'sd5 + 27'sd128) >>> 8);
			v1_s5 <= 25'(tfine_s4) - 25'(T_OFFSET);
			adcp_s5 <= adcp_s4;

			neg_s6 <= tc_s5[18];
			prod_s6 <= 36'(mag) * 36'(RECIP_10);
			tc_s6 <= tc_s5;
			v1_s6 <= v1_s5;
			adcp_s6 <= adcp_s5;

			tenths_s7 <= neg_s6 ? 16'(16'd0 - {1'b0, prod_s6[35:21]}) : {1'b0, prod_s6[35:21]};
			tc_s7 <= 32'(tc_s6);
			v1_s7 <= v1_s6;
			adcp_s7 <= adcp_s6;
		end
	end

	assign push = vld_s7 & en;
	assign push_item.adc_p = adcp_s7;
	assign push_item.v1 = v1_s7;
	assign push_item.tc = tc_s7;
	assign push_item.tenths = tenths_s7;

endmodule

// ===== src/ptc_queue.sv =====
// four-entry queue between the front and back parts
// depends on ptc_pkg
module ptc_queue import ptc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  ptc_item_t push_item,
	input  logic      pop,
	output ptc_item_t head,
	output logic      full,
	output logic      empty
);

	ptc_item_t   mem [4];
	logic [1:0]  wr_ptr_q;
	logic [1:0]  rd_ptr_q;
	logic [2:0]  cnt_q;

	assign full = (cnt_q == 3'd4);
	assign empty = (cnt_q == 3'd0);
	assign head = mem[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 2'd0;
			rd_ptr_q <= 2'd0;
			cnt_q <= 3'd0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 2'd1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 2'd1;
			if (push && !pop)
				cnt_q <= cnt_q + 3'd1;
			else if (pop && !push)
				cnt_q <= cnt_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem[wr_ptr_q] <= push_item;
	end

endmodule

// ===== src/ptc_sdiv.sv =====
// pipelined restoring divider, one quotient bit per stage, 64 stages
// depends on ptc_pkg
module ptc_sdiv import ptc_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  ptc_div_in_t  din,
	output ptc_div_out_t dout
);

	logic        vld_s [64];
	logic        neg_s [64];
	logic [63:0] dq_s  [64];
	logic [30:0] rem_s [64];
	logic [30:0] ub_s  [64];
	ptc_tag_t    tag_s [64];

	logic [63:0] nxt_dq  [64];
	logic [30:0] nxt_rem [64];

	always_comb begin
		logic [31:0] trial;
		logic        ge;
		trial = {31'd0, din.ua[63]};
		ge = trial >= {1'b0, din.ub};
		nxt_rem[0] = ge ? 31'(trial - {1'b0, din.ub}) : trial[30:0];
		nxt_dq[0] = {din.ua[62:0], ge};
		for (int k = 1; k < 64; k++) begin
			trial = {rem_s[k-1], dq_s[k-1][63]};
			ge = trial >= {1'b0, ub_s[k-1]};
			nxt_rem[k] = ge ? 31'(trial - {1'b0, ub_s[k-1]}) : trial[30:0];
			nxt_dq[k] = {dq_s[k-1][62:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 64; k++)
				vld_s[k] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= din.vld;
			for (int k = 1; k < 64; k++)
				vld_s[k] <= vld_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s[0] <= din.neg;
			ub_s[0] <= din.ub;
			tag_s[0] <= din.tag;
			for (int k = 1; k < 64; k++) begin
				neg_s[k] <= neg_s[k-1];
				ub_s[k] <= ub_s[k-1];
				tag_s[k] <= tag_s[k-1];
			end
			for (int k = 0; k < 64; k++) begin
				rem_s[k] <= nxt_rem[k];
				dq_s[k] <= nxt_dq[k];
			end
		end
	end

	assign dout.vld = vld_s[63];
	assign dout.neg = neg_s[63];
	assign dout.quo = dq_s[63];
	assign dout.tag = tag_s[63];

endmodule

// ===== src/ptc_back.sv =====
// back part: 64-bit pressure compensation, division, clamping and result register
// depends on ptc_pkg, ptc_if and ptc_sdiv
module ptc_back import ptc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  ptc_coeff_t coeff,
	input  logic       q_empty,
	input  ptc_item_t  head,
	output logic       pop,
	ptc_out_if.source  out_ch
);

	logic en;
	logic signed [24:0] v1h;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic vld_s8, vld_s9, vld_s10, vld_s11, vld_s12, vld_s13, vld_s14, vld_s15, vld_s16;

	logic signed [49:0] sq_s1;
	logic signed [40:0] m5_s1, m2_s1, m5_s2, m2_s2;
	logic [20:0]        np_s1, np_s2, np_s3;
	logic signed [63:0] x6_s2, x3_s2;
	logic signed [63:0] v2_s3, v1b_s3;
	logic signed [63:0] y_s4, num0_s4, num_s5;
	logic signed [30:0] div_s5;
	logic               pv_s6;
	logic               neg_s6;
	logic [63:0]        ua_s6;
	logic [30:0]        ub_s6;
	logic [31:0] tc_s1, tc_s2, tc_s3, tc_s4, tc_s5, tc_s6;
	logic [15:0] tn_s1, tn_s2, tn_s3, tn_s4, tn_s5, tn_s6;

	ptc_div_in_t  din;
	ptc_div_out_t dout;

	logic signed [63:0] q_s8, q_s9, q_s10, q_s11;
	logic signed [63:0] sh;
	logic [63:0]        ll_s9, sqq_s10;
	logic [31:0]        lh_s9;
	logic signed [63:0] p8q_s9, v2b_s10, v2b_s11, t_s11, sum_s12, pf_s13;
	logic [31:0]        pq_s14, pq_s15, pq_s16;
	logic [49:0]        hp_s15;
	logic [15:0]        hpa_s16;
	ptc_tag_t tag_s8, tag_s9, tag_s10, tag_s11, tag_s12, tag_s13, tag_s14, tag_s15, tag_s16;

	assign en = !vld_s16 || out_ch.ready;
	assign pop = en & !q_empty;
	assign v1h = $signed(head.v1);
	assign sh = q_s8 >>> 13;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
			vld_s12 <= 1'b0;
			vld_s13 <= 1'b0;
			vld_s14 <= 1'b0;
			vld_s15 <= 1'b0;
			vld_s16 <= 1'b0;
		end else if (en) begin
			vld_s1 <= pop;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s8 <= dout.vld;
			vld_s9 <= vld_s8;
			vld_s10 <= vld_s9;
			vld_s11 <= vld_s10;
			vld_s12 <= vld_s11;
			vld_s13 <= vld_s12;
			vld_s14 <= vld_s13;
			vld_s15 <= vld_s14;
			vld_s16 <= vld_s15;
		end
	end

	// pressure terms up to the divider
	always_ff @(posedge clk) begin
		if (en) begin
			sq_s1 <= 50'(v1h) * 50'(v1h);
			m5_s1 <= 41'(v1h) * 41'($signed(coeff.p5));
			m2_s1 <= 41'(v1h) * 41'($signed(coeff.p2));
			np_s1 <= 21'(P_BASE) - {1'b0, head.adc_p};
			tc_s1 <= head.tc;
			tn_s1 <= head.tenths;

			x6_s2 <= 64'(sq_s1) * 64'($signed(coeff.p6));
			x3_s2 <= 64'(sq_s1) * 64'($signed(coeff.p3));
			m5_s2 <= m5_s1;
			m2_s2 <= m2_s1;
			np_s2 <= np_s1;
			tc_s2 <= tc_s1;
			tn_s2 <= tn_s1;

			v2_s3 <= x6_s2 + (64'(m5_s2) <<< 17) + (64'($signed(coeff.p4)) <<< 35);
			v1b_s3 <= (x3_s2 >>> 8) + (64'(m2_s2) <<< 12) + P_BIAS;
			np_s3 <= np_s2;
			tc_s3 <= tc_s2;
			tn_s3 <= tn_s2;

			y_s4 <= v1b_s3 * $signed(64'(coeff.p1));
			num0_s4 <= $signed(64'(np_s3) << 31) - v2_s3;
			tc_s4 <= tc_s3;
			tn_s4 <= tn_s3;

			num_s5 <= num0_s4 * 64'(P_SCALE);
			div_s5 <= 31'(y_s4 >>> 33);
			tc_s5 <= tc_s4;
			tn_s5 <= tn_s4;

			pv_s6 <= (div_s5 != 31'sd0);
			neg_s6 <= num_s5[63] ^ div_s5[30];
			ua_s6 <= num_s5[63] ? 64'(-num_s5) : 64'(num_s5);
			ub_s6 <= div_s5[30] ? 31'(-div_s5) : 31'(div_s5);
			tc_s6 <= tc_s5;
			tn_s6 <= tn_s5;
		end
	end

	assign din.vld = vld_s6;
	assign din.neg = neg_s6;
	assign din.ua = ua_s6;
	assign din.ub = ub_s6;
	assign din.tag.pvalid = pv_s6;
	assign din.tag.tc = tc_s6;
	assign din.tag.tenths = tn_s6;

	ptc_sdiv u_sdiv (
		.clk   (clk),
		.arst_n(arst_n),
		.en    (en),
		.din   (din),
		.dout  (dout)
	);

	// correction terms, clamp and hectopascal conversion
	always_ff @(posedge clk) begin
		if (en) begin
			q_s8 <= dout.neg ? -$signed(dout.quo) : $signed(dout.quo);
			tag_s8 <= dout.tag;

			ll_s9 <= 64'(sh[31:0]) * 64'(sh[31:0]);
			lh_s9 <= sh[31:0] * sh[63:32];
			p8q_s9 <= q_s8 * 64'($signed(coeff.p8));
			q_s9 <= q_s8;
			tag_s9 <= tag_s8;

			sqq_s10 <= ll_s9 + {lh_s9[30:0], 1'b0, 32'd0};
			v2b_s10 <= p8q_s9 >>> 19;
			q_s10 <= q_s9;
			tag_s10 <= tag_s9;

			t_s11 <= $signed(sqq_s10) * 64'($signed(coeff.p9));
			v2b_s11 <= v2b_s10;
			q_s11 <= q_s10;
			tag_s11 <= tag_s10;

			sum_s12 <= q_s11 + (t_s11 >>> 25) + v2b_s11;
			tag_s12 <= tag_s11;

			pf_s13 <= (sum_s12 >>> 8) + (64'($signed(coeff.p7)) <<< 4);
			tag_s13 <= tag_s12;

			if (!tag_s13.pvalid || pf_s13[63])
				pq_s14 <= 32'd0;
			else if (|pf_s13[62:32])
				pq_s14 <= 32'hFFFF_FFFF;
			else
				pq_s14 <= pf_s13[31:0];
			tag_s14 <= tag_s13;

			hp_s15 <= 50'(pq_s14[31:10]) * 50'(RECIP_25);
			pq_s15 <= pq_s14;
			tag_s15 <= tag_s14;

			hpa_s16 <= (|hp_s15[49:48]) ? 16'hFFFF : hp_s15[47:32];
			pq_s16 <= pq_s15;
			tag_s16 <= tag_s15;
		end
	end

	assign out_ch.valid = vld_s16;
	assign out_ch.temperature_centi = $signed(tag_s16.tc);
	assign out_ch.pressure_q24_8 = pq_s16;
	assign out_ch.pressure_valid = tag_s16.pvalid;
	assign out_ch.temperature_tenths = $signed(tag_s16.tenths);
	assign out_ch.pressure_hpa = hpa_s16;

endmodule

// ===== src/pressure_temperature_compensation_top.sv =====
// top level of the pressure/temperature compensation block
// depends on ptc_pkg, ptc_if, ptc_front, ptc_queue and ptc_back
//
// Takes one raw pressure/temperature transaction per clock and returns one compensated
// result per transaction in order, sustaining one transaction per cycle while the output
// channel is ready and the queue is not full. The pressure path runs through the
// 64-stage signed divider; a seven-stage temperature front feeds the pressure back
// through a four-entry queue. The user must write calibration words on the cfg port only
// while no transaction is in flight; the block itself does not enforce this.
module pressure_temperature_compensation_top import ptc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	ptc_in_if.sink      in_ch,
	ptc_out_if.source   out_ch,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [47:0] cfg_wdata
);

	ptc_coeff_t coeff_q;
	logic       push;
	ptc_item_t  push_item;
	logic       pop;
	ptc_item_t  head;
	logic       full;
	logic       empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coeff_q <= '0;
		end else if (cfg_we) begin
			case (ptc_reg_t'(cfg_index))
				REG_T1: coeff_q.t1 <= cfg_wdata[15:0];
				REG_T2: coeff_q.t2 <= cfg_wdata[15:0];
				REG_T3: coeff_q.t3 <= cfg_wdata[15:0];
				REG_P1: coeff_q.p1 <= cfg_wdata[15:0];
				REG_P2: coeff_q.p2 <= cfg_wdata[15:0];
				REG_P3: coeff_q.p3 <= cfg_wdata[15:0];
				REG_P456: begin
					coeff_q.p4 <= cfg_wdata[15:0];
					coeff_q.p5 <= cfg_wdata[31:16];
					coeff_q.p6 <= cfg_wdata[47:32];
				end
				REG_P789: begin
					coeff_q.p7 <= cfg_wdata[15:0];
					coeff_q.p8 <= cfg_wdata[31:16];
					coeff_q.p9 <= cfg_wdata[47:32];
				end
				default: ;
			endcase
		end
	end

	ptc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.coeff    (coeff_q),
		.push_ok  (!full),
		.push     (push),
		.push_item(push_item)
	);

	ptc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_item(push_item),
		.pop      (pop),
		.head     (head),
		.full     (full),
		.empty    (empty)
	);

	ptc_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.coeff  (coeff_q),
		.q_empty(empty),
		.head   (head),
		.pop    (pop),
		.out_ch (out_ch)
	);

endmodule
